// ----- hdl/red_marker_mask_with_opening_core_assert.svh -----
// Assertion macros for the red marker mask core.
// Needs clk and rst_n in the scope of the module that expands them.
`ifndef RED_MARKER_MASK_WITH_OPENING_CORE_ASSERT_SVH
`define RED_MARKER_MASK_WITH_OPENING_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define RMASK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RMASK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMASK_ASSERT_IMP(lbl, ante, cons, msg)
`define RMASK_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/rmask_pkg.sv -----
// Shared types and constants of the red marker mask core.
// No dependencies; imported by the core.
package rmask_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int MIN_SIZE        = 3;
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam logic [3:0] RST_RG_GAIN = 4'd7;
    localparam logic [3:0] RST_GB_GAIN = 4'd7;
    localparam logic [7:0] RST_RED_MIN = 8'd50;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_RG_GAIN      = 3'd2,
        REG_GB_GAIN      = 3'd3,
        REG_RED_MIN      = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } in_item_t;

    typedef struct packed {
        logic mask;
        logic frame_end;
    } out_item_t;

endpackage

// ----- hdl/rmask_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rmask_ram
#(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/red_marker_mask_with_opening_core.sv -----
// Red marker mask with 3x3 opening: color-ratio threshold, erosion, dilation.
// Depends on rmask_pkg, rmask_ram and red_marker_mask_with_opening_core_assert.svh.
//
// Takes one BGR pixel (or drain tick) per clock in raster order and returns the
// opened mask in raster order, two rows and two pixels behind the input; after
// the last pixel of a frame, 2*W+2 drain ticks push out the rest, the final one
// flagged frame_end. Throughput is one item per clock; in_stall rises only when
// out_stall has backed up the three-register pipeline (input register, erosion
// stage, output register); a result passes through them in that order. Two line
// RAMs of MAX_WIDTH x 2 bits (threshold rows, eroded rows), each with one read
// and one write per clock, hold the previous two rows; they need no clearing
// after reset. Frame size is latched at the first pixel of a frame; configuration
// writes are taken at any time (cfg_ready is always high).
`include "red_marker_mask_with_opening_core_assert.svh"

module red_marker_mask_with_opening_core
    import rmask_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [CW-1:0] col;
    } pos_t;

    // mask order: top, bottom, left, right neighbors inside the image
    typedef struct packed {
        logic          thr;
        logic [CW-1:0] col;
        logic          slot;
        logic          ero_in;
        logic [3:0]    emask;
        logic [CW-1:0] ecol;
        logic          emit;
        logic [3:0]    dmask;
        logic          fend;
    } a_stage_t;

    typedef struct packed {
        logic          ebit;
        logic [CW-1:0] ecol;
        logic          emit;
        logic [3:0]    dmask;
        logic          fend;
    } b_stage_t;

    // win: {left, mid, right} columns, each {top, mid, bottom}
    function automatic logic window_and(input logic [8:0] win, input logic [3:0] m);
        logic [2:0] rok;
        logic [2:0] cok;
        logic       acc;
        rok = {m[3], 1'b1, m[2]};
        cok = {m[1], 1'b1, m[0]};
        acc = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                acc = acc & (win[c*3 + r] | ~(cok[c] & rok[r]));
            end
        end
        return acc;
    endfunction

    function automatic logic window_or(input logic [8:0] win, input logic [3:0] m);
        logic [2:0] rok;
        logic [2:0] cok;
        logic       acc;
        rok = {m[3], 1'b1, m[2]};
        cok = {m[1], 1'b1, m[0]};
        acc = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                acc = acc | (win[c*3 + r] & cok[c] & rok[r]);
            end
        end
        return acc;
    endfunction

    function automatic pos_t advance(input pos_t p, input logic [WW-1:0] w);
        pos_t n;
        if (WW'(p.col) == w - WW'(1))
        begin
            n.row = p.row + RW'(1);
            n.col = '0;
        end
        else
        begin
            n.row = p.row;
            n.col = p.col + CW'(1);
        end
        return n;
    endfunction

    // configuration
    logic [WW-1:0] img_w_reg, img_w_next;
    logic [HW-1:0] img_h_reg, img_h_next;
    logic [3:0]    rg_gain_reg, rg_gain_next;
    logic [3:0]    gb_gain_reg, gb_gain_next;
    logic [7:0]    red_min_reg, red_min_next;

    // frame position
    logic [WW-1:0] frame_w_reg, frame_w_next;
    logic [RW-1:0] frame_h_reg, frame_h_next;
    pos_t          in_pos_reg, in_pos_next;
    pos_t          ero_pos_reg, ero_pos_next;
    pos_t          out_pos_reg, out_pos_next;

    // pipeline
    logic          a_valid_reg, a_valid_next;
    a_stage_t      a_reg, a_next;
    logic          b_valid_reg, b_valid_next;
    b_stage_t      b_reg, b_next;
    logic [5:0]    t_win_reg;
    logic [5:0]    d_win_reg;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_item_reg;

    logic          in_fire, a_fire, b_fire, out_free, out_load;
    logic          is_drain, frame_done, restart, active;
    logic [WW-1:0] cur_w;
    logic [RW-1:0] cur_h;
    pos_t          pi, pe, po;
    logic [12:0]   rg_prod, gb_prod, g_ten, b_ten;
    logic          thr, slot, emit, fend;
    logic [1:0]    t_rd, e_rd;
    logic [2:0]    t_new, d_new;
    logic          ebit, dil;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        img_w_next   = img_w_reg;
        img_h_next   = img_h_reg;
        rg_gain_next = rg_gain_reg;
        gb_gain_next = gb_gain_reg;
        red_min_next = red_min_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_data < CFG_DATA_W'(MIN_SIZE))
                        img_w_next = WW'(MIN_SIZE);
                    else if (32'(cfg_data) > MAX_WIDTH)
                        img_w_next = WW'(MAX_WIDTH);
                    else
                        img_w_next = WW'(cfg_data);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_data < CFG_DATA_W'(MIN_SIZE))
                        img_h_next = HW'(MIN_SIZE);
                    else if (32'(cfg_data) > MAX_HEIGHT)
                        img_h_next = HW'(MAX_HEIGHT);
                    else
                        img_h_next = HW'(cfg_data);
                end
                REG_RG_GAIN: rg_gain_next = cfg_data[3:0];
                REG_GB_GAIN: gb_gain_next = cfg_data[3:0];
                REG_RED_MIN: red_min_next = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign b_fire   = b_valid_reg && (!b_reg.emit || out_free);
    assign a_fire   = a_valid_reg && (!b_valid_reg || b_fire);
    assign in_stall = a_valid_reg && !a_fire;
    assign in_fire  = in_valid && !in_stall;
    assign out_load = b_fire && b_reg.emit;

    // tick decode on the incoming item
    always_comb
    begin
        is_drain   = (in_item.mode == MODE_DRAIN);
        frame_done = (in_pos_reg.row >= frame_h_reg);
        restart    = !is_drain && ((in_pos_reg == '0) || frame_done);
        active     = !is_drain || frame_done;
        cur_w      = restart ? img_w_reg : frame_w_reg;
        cur_h      = restart ? RW'(img_h_reg) : frame_h_reg;
        pi         = restart ? '0 : in_pos_reg;
        pe         = restart ? '0 : ero_pos_reg;
        po         = restart ? '0 : out_pos_reg;

        // (x*c+4)/10 >= y  is  x*c+4 >= 10*y
        rg_prod = 13'(in_item.red) * 13'(rg_gain_reg) + 13'd4;
        gb_prod = 13'(in_item.green) * 13'(gb_gain_reg) + 13'd4;
        g_ten   = 13'(in_item.green) * 13'd10;
        b_ten   = 13'(in_item.blue) * 13'd10;
        thr     = !is_drain && (rg_prod >= g_ten) && (gb_prod >= b_ten) &&
                  (in_item.red >= red_min_reg);

        // erosion starts W+1 ticks in, output 2W+2 ticks in
        slot = (pi.row >= RW'(2)) || ((pi.row == RW'(1)) && (pi.col != '0));
        emit = (pi.row >= RW'(3)) || ((pi.row == RW'(2)) && (pi.col >= CW'(2)));
        fend = emit && (po.row == cur_h - RW'(1)) && (WW'(po.col) == cur_w - WW'(1));

        a_next.thr    = thr;
        a_next.col    = pi.col;
        a_next.slot   = slot;
        a_next.ero_in = (pe.row < cur_h);
        a_next.emask  = {pe.row != '0, (pe.row + RW'(1)) < cur_h,
                         pe.col != '0, WW'(pe.col) != cur_w - WW'(1)};
        a_next.ecol   = pe.col;
        a_next.emit   = emit;
        a_next.dmask  = {po.row != '0, (po.row + RW'(1)) < cur_h,
                         po.col != '0, WW'(po.col) != cur_w - WW'(1)};
        a_next.fend   = fend;
    end

    always_comb
    begin
        frame_w_next = frame_w_reg;
        frame_h_next = frame_h_reg;
        in_pos_next  = in_pos_reg;
        ero_pos_next = ero_pos_reg;
        out_pos_next = out_pos_reg;
        if (in_fire && active)
        begin
            frame_w_next = cur_w;
            frame_h_next = cur_h;
            if (fend)
            begin
                in_pos_next  = '0;
                ero_pos_next = '0;
                out_pos_next = '0;
            end
            else
            begin
                in_pos_next  = advance(pi, cur_w);
                ero_pos_next = slot ? advance(pe, cur_w) : pe;
                out_pos_next = emit ? advance(po, cur_w) : po;
            end
        end
    end

    // threshold rows: rd[0] one row up, rd[1] two rows up
    rmask_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_thr_ram (
        .clk     (clk),
        .wr_en   (a_fire),
        .wr_addr (a_reg.col),
        .wr_data ({t_rd[0], a_reg.thr}),
        .rd_en   (in_fire && active),
        .rd_addr (pi.col),
        .rd_data (t_rd)
    );

    assign t_new = {t_rd, a_reg.thr};
    assign ebit  = a_reg.ero_in && window_and({t_win_reg, t_new}, a_reg.emask);

    always_comb
    begin
        b_next.ebit  = ebit;
        b_next.ecol  = a_reg.ecol;
        b_next.emit  = a_reg.emit;
        b_next.dmask = a_reg.dmask;
        b_next.fend  = a_reg.fend;
    end

    rmask_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_ero_ram (
        .clk     (clk),
        .wr_en   (b_fire),
        .wr_addr (b_reg.ecol),
        .wr_data ({e_rd[0], b_reg.ebit}),
        .rd_en   (a_fire && a_reg.slot),
        .rd_addr (a_reg.ecol),
        .rd_data (e_rd)
    );

    assign d_new = {e_rd, b_reg.ebit};
    assign dil   = window_or({d_win_reg, d_new}, b_reg.dmask);

    always_comb
    begin
        if (in_fire && active)
            a_valid_next = 1'b1;
        else if (a_fire)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;

        if (a_fire)
            b_valid_next = a_reg.slot;
        else if (b_fire)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg     <= WW'(RST_W);
            img_h_reg     <= HW'(RST_H);
            rg_gain_reg   <= RST_RG_GAIN;
            gb_gain_reg   <= RST_GB_GAIN;
            red_min_reg   <= RST_RED_MIN;
            frame_w_reg   <= WW'(RST_W);
            frame_h_reg   <= RW'(RST_H);
            in_pos_reg    <= '0;
            ero_pos_reg   <= '0;
            out_pos_reg   <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            img_w_reg     <= img_w_next;
            img_h_reg     <= img_h_next;
            rg_gain_reg   <= rg_gain_next;
            gb_gain_reg   <= gb_gain_next;
            red_min_reg   <= red_min_next;
            frame_w_reg   <= frame_w_next;
            frame_h_reg   <= frame_h_next;
            in_pos_reg    <= in_pos_next;
            ero_pos_reg   <= ero_pos_next;
            out_pos_reg   <= out_pos_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && active)
        begin
            a_reg <= a_next;
        end
        if (a_fire)
        begin
            b_reg     <= b_next;
            t_win_reg <= {t_win_reg[2:0], t_new};
        end
        if (b_fire)
        begin
            d_win_reg <= {d_win_reg[2:0], d_new};
        end
        if (out_load)
        begin
            out_item_reg.mask      <= dil;
            out_item_reg.frame_end <= b_reg.fend;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `RMASK_ASSERT_IMP(a_stall_only_full, in_stall, a_valid_reg, "stall with empty input register")
    `RMASK_ASSERT_NXT(a_frame_wrap, in_fire && active && fend, (in_pos_reg == '0) && (ero_pos_reg == '0) && (out_pos_reg == '0), "counters not cleared after frame end")
    `RMASK_ASSERT_IMP(a_emit_in_slot, a_valid_reg && a_reg.emit, a_reg.slot, "output tick without erosion slot")
    `RMASK_ASSERT_NXT(a_drain_ignored, in_fire && !active, $stable(in_pos_reg) && $stable(frame_w_reg), "idle drain moved the frame position")

endmodule

// ----- sim/tb_red_marker_mask_with_opening_core.sv -----
`timescale 1ns / 1ps
// Testbench for red_marker_mask_with_opening_core: feeds BGR pixels and drain ticks,
// predicts the opened mask with its own line rings and checks every result transfer.
// Depends on rmask_pkg and the core RTL only.
module tb_red_marker_mask_with_opening_core;
    import rmask_pkg::*;

    localparam int MAX_W       = DEF_MAX_WIDTH;
    localparam int MAX_H       = DEF_MAX_HEIGHT;
    localparam int RING        = 2 * MAX_W + 3;
    localparam int NUM_REGS    = REG_RED_MIN + 1;
    localparam int RAND_ITEMS  = 1150;
    localparam int HOLD_CYCLES = 400;
    localparam int PIPE_SLACK  = 8;
    localparam int IDLE_CAP    = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int TIMEOUT_NS  = 20_000_000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;

    // register copy and the frame state it feeds
    int unsigned set_w    = RST_IMAGE_WIDTH;
    int unsigned set_h    = RST_IMAGE_HEIGHT;
    int unsigned set_rg   = RST_RG_GAIN;
    int unsigned set_gb   = RST_GB_GAIN;
    int unsigned set_rmin = RST_RED_MIN;
    int unsigned frm_w    = RST_IMAGE_WIDTH;
    int unsigned frm_h    = RST_IMAGE_HEIGHT;
    int unsigned frm_tick = 0;
    bit          thr_ring [RING];
    bit          ero_ring [RING];

    out_item_t   mask_due [$];
    in_item_t    pixel_feed [$];
    int unsigned err_cnt = 0;
    int unsigned rand_items = 0;
    bit          in_stall_seen = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;
    int unsigned hold_left = 0;
    int unsigned seg_left = 0;
    int unsigned stall_pct = 0;

    red_marker_mask_with_opening_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void apply_config(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_IMAGE_WIDTH:  set_w = fit_size(val, MAX_W);
            REG_IMAGE_HEIGHT: set_h = fit_size(val, MAX_H);
            REG_RG_GAIN:      set_rg = val[3:0];
            REG_GB_GAIN:      set_gb = val[3:0];
            REG_RED_MIN:      set_rmin = val[7:0];
            default:          ;
        endcase
    endfunction

    // 3x3 AND (erosion) or OR (dilation) around raster index idx; off-image taps skipped
    function automatic bit window3(input bit eroded, input int unsigned idx, input bit want_all);
        int row, col, r, c, dr, dc, k;
        bit acc, b;
        row = idx / frm_w;
        col = idx % frm_w;
        acc = want_all;
        for (dr = -1; dr <= 1; dr++)
        begin
            for (dc = -1; dc <= 1; dc++)
            begin
                r = row + dr;
                c = col + dc;
                if (r >= 0 && r < int'(frm_h) && c >= 0 && c < int'(frm_w))
                begin
                    k = (r * int'(frm_w) + c) % RING;
                    b = eroded ? ero_ring[k] : thr_ring[k];
                    acc = want_all ? (acc & b) : (acc | b);
                end
            end
        end
        return acc;
    endfunction

    function automatic void predict_opening(input in_item_t it);
        int unsigned total, t, r, g, b, e, q;
        bit mark;
        out_item_t res;
        total = frm_w * frm_h;
        if (it.mode == MODE_DRAIN)
        begin
            if (frm_tick < total)
                return;
        end
        else
        begin
            // first pixel of a frame, or a pixel cutting off an unfinished flush
            if (frm_tick == 0 || frm_tick >= total)
            begin
                frm_tick = 0;
                frm_w = set_w;
                frm_h = set_h;
                total = frm_w * frm_h;
            end
            r = it.red;
            g = it.green;
            b = it.blue;
            mark = ((r * set_rg + 4) / 10 >= g) && ((g * set_gb + 4) / 10 >= b) &&
                   (r >= set_rmin);
            thr_ring[frm_tick % RING] = mark;
        end
        t = frm_tick;
        if (t >= frm_w + 1 && t - (frm_w + 1) < total)
        begin
            e = t - (frm_w + 1);
            ero_ring[e % RING] = window3(1'b0, e, 1'b1);
        end
        frm_tick = t + 1;
        if (t >= 2 * frm_w + 2 && t - (2 * frm_w + 2) < total)
        begin
            q = t - (2 * frm_w + 2);
            res.mask = window3(1'b1, q, 1'b0);
            res.frame_end = (q == total - 1);
            if (res.frame_end)
                frm_tick = 0;
            mask_due.push_back(res);
        end
    endfunction

    function automatic void flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    // results are checked before the same edge's input transfer is predicted
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n)
        begin
            in_stall_seen = (in_stall !== 1'b0);
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (mask_due.size() == 0)
                    flag_error($sformatf("unexpected result mask=%0b frame_end=%0b",
                                         out_item.mask, out_item.frame_end));
                else
                begin
                    want = mask_due.pop_front();
                    if (out_item.mask !== want.mask || out_item.frame_end !== want.frame_end)
                        flag_error($sformatf("expected mask=%0b frame_end=%0b, got mask=%0b frame_end=%0b",
                                             want.mask, want.frame_end,
                                             out_item.mask, out_item.frame_end));
                end
            end
            if (in_valid && in_stall === 1'b0)
                predict_opening(in_item);
        end
    end

    // sender: bursts of random length, random gaps, stalled payload held
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && in_stall_seen))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pixel_feed.size() != 0)
            begin
                in_item <= pixel_feed.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(48, 1);
                    gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: segments of random stall density, plus long holds on request
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(80, 8);
                case ($urandom_range(3, 0))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    function automatic in_item_t pix(input int unsigned r, input int unsigned g,
                                     input int unsigned b);
        in_item_t p;
        p.mode = MODE_PIXEL;
        p.red = r;
        p.green = g;
        p.blue = b;
        return p;
    endfunction

    function automatic in_item_t drain_tick();
        in_item_t p;
        p.mode = MODE_DRAIN;
        p.red = $urandom_range(255, 0);
        p.green = $urandom_range(255, 0);
        p.blue = $urandom_range(255, 0);
        return p;
    endfunction

    // marked pixels are built to pass all three tests under the current registers
    function automatic in_item_t make_pixel(input bit marked);
        in_item_t p;
        int unsigned lim;
        p = drain_tick();
        p.mode = MODE_PIXEL;
        if (marked)
        begin
            p.red = $urandom_range(255, set_rmin);
            lim = (p.red * set_rg + 4) / 10;
            p.green = $urandom_range(lim > 255 ? 255 : lim, 0);
            lim = (p.green * set_gb + 4) / 10;
            p.blue = $urandom_range(lim > 255 ? 255 : lim, 0);
        end
        return p;
    endfunction

    // one frame with a random red blob; optional stray drain tick inside the frame
    task automatic push_frame(input int unsigned npix, input int unsigned ndrain,
                              input bit stray);
        int unsigned r0, r1, c0, c1, row, col, stray_at, i;
        r0 = $urandom_range(set_h - 1, 0);
        r1 = $urandom_range(set_h - 1, r0);
        c0 = $urandom_range(set_w - 1, 0);
        c1 = $urandom_range(set_w - 1, c0);
        stray_at = stray ? $urandom_range(npix - 1, 1) : npix;
        for (i = 0; i < npix; i++)
        begin
            if (i == stray_at)
                pixel_feed.push_back(drain_tick());
            row = (i / set_w) % set_h;
            col = i % set_w;
            pixel_feed.push_back(make_pixel(row >= r0 && row <= r1 && col >= c0 && col <= c1 &&
                                            $urandom_range(9, 0) != 0));
        end
        repeat (ndrain) pixel_feed.push_back(drain_tick());
        rand_items += npix + ndrain;
    endtask

    task automatic write_reg(input int unsigned idx, input int unsigned val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        apply_config(cfg_index, cfg_data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned rg,
                             input int unsigned gb, input int unsigned rmin);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_RG_GAIN, rg);
        write_reg(REG_GB_GAIN, gb);
        write_reg(REG_RED_MIN, rmin);
    endtask

    // all items taken and all results back, then slack for ticks that yield nothing
    task automatic wait_idle();
        int unsigned n;
        n = 0;
        while ((pixel_feed.size() != 0 || in_valid || mask_due.size() != 0) && n < IDLE_CAP)
        begin
            @(posedge clk);
            n++;
        end
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned phase, kind, full, lag, frames, saved, i;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain ticks with no frame open are dropped
        pixel_feed.push_back(drain_tick());
        pixel_feed.push_back(drain_tick());
        wait_idle();

        // undersized frame clamps to 3x3; gain above ten; red floor at max
        configure(2, 0, 15, 10, 255);
        for (i = NUM_REGS; i < (1 << CFG_INDEX_W); i++)
            write_reg(i, (1 << CFG_DATA_W) - 1);

        pixel_feed.push_back(pix(255, 0, 0));
        pixel_feed.push_back(pix(255, 255, 255));
        pixel_feed.push_back(pix(255, 255, 0));
        pixel_feed.push_back(pix(255, 0, 0));
        pixel_feed.push_back(drain_tick());         // frame not complete: ignored
        pixel_feed.push_back(pix(255, 128, 127));
        pixel_feed.push_back(pix(254, 255, 0));
        pixel_feed.push_back(pix(255, 0, 1));
        pixel_feed.push_back(pix(255, 255, 255));
        pixel_feed.push_back(pix(255, 1, 1));
        repeat (3) pixel_feed.push_back(drain_tick());
        // new frame cuts off the rest of the flush
        pixel_feed.push_back(pix(255, 255, 255));
        pixel_feed.push_back(pix(255, 0, 0));
        pixel_feed.push_back(pix(0, 0, 0));
        pixel_feed.push_back(pix(255, 10, 3));
        wait_idle();

        // width write lands mid-frame: only the next frame sees it
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_RED_MIN, 0);
        pixel_feed.push_back(pix(0, 0, 0));
        pixel_feed.push_back(pix(255, 0, 0));
        pixel_feed.push_back(pix(0, 1, 0));
        pixel_feed.push_back(pix(255, 255, 255));
        pixel_feed.push_back(pix(128, 200, 100));
        repeat (8) pixel_feed.push_back(drain_tick());
        wait_idle();

        rand_items = 0;
        phase = 0;
        while (rand_items < RAND_ITEMS)
        begin
            case (phase)
                0:       configure((1 << CFG_DATA_W) - 1, 3, 10, 10, 0);
                1:       configure(3, MAX_H, 0, 0, 255);
                2:       configure(5, 4, 15, 15, 128);
                default: configure(($urandom_range(9, 0) == 0) ? $urandom_range(2, 0)
                                                               : $urandom_range(8, 3),
                                   ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0)
                                                               : $urandom_range(6, 3),
                                   $urandom_range(15, 0),
                                   $urandom_range(1, 0) ? $urandom_range(15, 0)
                                                        : $urandom_range(12, 8),
                                   $urandom_range(1, 0) ? $urandom_range(255, 0)
                                                        : $urandom_range(100, 0));
            endcase
            if (phase % 6 == 0)
                hold_req++;
            full = set_w * set_h;
            lag = 2 * set_w + 2;
            saved = rand_items;
            frames = (full > 100) ? 1 : $urandom_range(4, 1);
            repeat (frames)
            begin
                kind = (full > 100) ? 0 : $urandom_range(9, 0);
                case (kind)
                    6: push_frame(full, $urandom_range(lag - 1, 0), 1'b0);
                    7: push_frame(full, lag, 1'b1);
                    8: push_frame($urandom_range(full - 1, 1), 0, 1'b0);
                    9: repeat ($urandom_range(3, 1)) pixel_feed.push_back(drain_tick());
                    default: push_frame(full, lag + ((kind == 1) ? $urandom_range(2, 1) : 0),
                                        1'b0);
                endcase
            end
            // the wide and tall extremes don't count toward the random budget
            if (full > 100)
                rand_items = saved;
            wait_idle();
            phase++;
        end

        wait_idle();
        repeat (4 * PIPE_SLACK) @(posedge clk);
        if (mask_due.size() != 0)
            $display("%0d expected results never arrived", mask_due.size());
        if (err_cnt == 0 && mask_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rmask_pkg.sv
hdl/rmask_ram.sv
hdl/red_marker_mask_with_opening_core.sv
sim/tb_red_marker_mask_with_opening_core.sv
